>>> rtl/shabsh_pkg.sv
// shabsh_pkg: shared types, constants and helper functions for the sha-256 hasher
// used by shabsh_round and sha256_byte_stream_hasher; no dependencies of its own
package shabsh_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [0:7] hash_type;

   // command codes on the request channel
   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // padding constants and last-index limits
   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] PAD_LEN_POS = 6'd56;
   localparam logic [5:0] LAST_BYTE   = 6'd63;
   localparam logic [5:0] LAST_ROUND  = 6'd63;
   localparam logic [2:0] LAST_WORD   = 3'd7;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   localparam hash_type H_INIT = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // rotate right by a constant amount
   function automatic word_type rotr(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   // round constant table
   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h00000000;
      endcase
      return k;
   endfunction

endpackage

>>> rtl/shabsh_round.sv
// shabsh_round: one sha-256 compression round plus one message schedule step
// depends on shabsh_pkg for word types and rotate helper
module shabsh_round (
   input  shabsh_pkg::hash_type work_i,
   input  shabsh_pkg::word_type k_t,
   input  shabsh_pkg::word_type w_t,
   input  shabsh_pkg::word_type w_1,
   input  shabsh_pkg::word_type w_9,
   input  shabsh_pkg::word_type w_14,
   output shabsh_pkg::hash_type work_o,
   output shabsh_pkg::word_type w_new
);

   shabsh_pkg::word_type big_s1, big_s0, ch, maj, t1, t2, sig0, sig1;

   // round function
   always_comb begin
      big_s1 = shabsh_pkg::rotr(work_i[4], 5'd6) ^ shabsh_pkg::rotr(work_i[4], 5'd11)
             ^ shabsh_pkg::rotr(work_i[4], 5'd25);
      ch     = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
      t1     = work_i[7] + big_s1 + ch + k_t + w_t;
      big_s0 = shabsh_pkg::rotr(work_i[0], 5'd2) ^ shabsh_pkg::rotr(work_i[0], 5'd13)
             ^ shabsh_pkg::rotr(work_i[0], 5'd22);
      maj    = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
      t2     = big_s0 + maj;
      work_o[0] = t1 + t2;
      work_o[1] = work_i[0];
      work_o[2] = work_i[1];
      work_o[3] = work_i[2];
      work_o[4] = work_i[3] + t1;
      work_o[5] = work_i[4];
      work_o[6] = work_i[5];
      work_o[7] = work_i[6];
   end

   // schedule word sixteen rounds ahead, in parallel with the round
   always_comb begin
      sig0  = shabsh_pkg::rotr(w_1, 5'd7) ^ shabsh_pkg::rotr(w_1, 5'd18) ^ (w_1 >> 3);
      sig1  = shabsh_pkg::rotr(w_14, 5'd17) ^ shabsh_pkg::rotr(w_14, 5'd19) ^ (w_14 >> 10);
      w_new = sig1 + w_9 + sig0 + w_t;
   end

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// sha256_byte_stream_hasher: byte-serial sha-256 with in-block padding and digest readout
// depends on shabsh_pkg and shabsh_round
//
//   channel | direction | payload              | handshake
//   req     | in        | shabsh_pkg::req_type | req_valid / req_ready
//   rsp     | out       | shabsh_pkg::rsp_type | rsp_valid / rsp_ready
//
// the 64th byte of a block starts a compression of 64 rounds through the single
// shared round unit, then a fold into the hash
// a finish transfer is followed by the padding bytes and the compression of each
// padding block, then eight result transfers
// req_ready is low while padding, compressing or presenting the digest
// reset is synchronous, active high, and loads the initial hash values
module sha256_byte_stream_hasher (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  shabsh_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output shabsh_pkg::rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_FOLD  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [63:0]          bitlen_ff, bitlen_in;
   logic [5:0]           round_ff, round_in;
   logic                 fin_ff, fin_in;
   logic                 mark_ff, mark_in;
   logic                 last_blk_ff, last_blk_in;
   logic [2:0]           out_idx_ff, out_idx_in;
   shabsh_pkg::hash_type hash_ff, hash_in;
   shabsh_pkg::hash_type work_ff, work_in;
   logic [511:0]         blk_ff, blk_in;

   shabsh_pkg::hash_type work_next;
   shabsh_pkg::word_type w_new;
   logic [7:0]           pad_byte;

   // shared round unit; schedule taps at fixed places of the block shift line
   shabsh_round u_round (
      .work_i (work_ff),
      .k_t    (shabsh_pkg::round_k(round_ff)),
      .w_t    (blk_ff[511 -: 32]),
      .w_1    (blk_ff[479 -: 32]),
      .w_9    (blk_ff[223 -: 32]),
      .w_14   (blk_ff[63 -: 32]),
      .work_o (work_next),
      .w_new  (w_new)
   );

   // padding byte: marker, zeros, then the big-endian bit length
   always_comb begin
      if (!mark_ff) begin
         pad_byte = shabsh_pkg::PAD_MARK;
      end else if (last_blk_ff && (cnt_ff >= shabsh_pkg::PAD_LEN_POS)) begin
         pad_byte = bitlen_ff[{~cnt_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      bitlen_in   = bitlen_ff;
      round_in    = round_ff;
      fin_in      = fin_ff;
      mark_in     = mark_ff;
      last_blk_in = last_blk_ff;
      out_idx_in  = out_idx_ff;
      hash_in     = hash_ff;
      work_in     = work_ff;
      blk_in      = blk_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.command == shabsh_pkg::CMD_FINISH) begin
                  fin_in   = 1'b1;
                  mark_in  = 1'b0;
                  state_in = S_PAD;
               end else begin
                  blk_in    = {blk_ff[503:0], req_data.data_byte};
                  cnt_in    = cnt_ff + 6'd1;
                  bitlen_in = bitlen_ff + 64'd8;
                  if (cnt_ff == shabsh_pkg::LAST_BYTE) begin
                     work_in  = hash_ff;
                     state_in = S_ROUND;
                  end
               end
            end
         end
         S_PAD: begin
            blk_in = {blk_ff[503:0], pad_byte};
            cnt_in = cnt_ff + 6'd1;
            if (!mark_ff) begin
               mark_in     = 1'b1;
               last_blk_in = (cnt_ff < shabsh_pkg::PAD_LEN_POS);
            end
            if (cnt_ff == shabsh_pkg::LAST_BYTE) begin
               work_in  = hash_ff;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            work_in  = work_next;
            blk_in   = {blk_ff[479:0], w_new};
            round_in = round_ff + 6'd1;
            if (round_ff == shabsh_pkg::LAST_ROUND) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            if (!fin_ff) begin
               state_in = S_IDLE;
            end else if (last_blk_ff) begin
               out_idx_in = 3'd0;
               state_in   = S_OUT;
            end else begin
               last_blk_in = 1'b1;
               state_in    = S_PAD;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == shabsh_pkg::LAST_WORD) begin
                  hash_in   = shabsh_pkg::H_INIT;
                  cnt_in    = 6'd0;
                  bitlen_in = 64'd0;
                  fin_in    = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= 6'd0;
         bitlen_ff   <= 64'd0;
         round_ff    <= 6'd0;
         fin_ff      <= 1'b0;
         mark_ff     <= 1'b0;
         last_blk_ff <= 1'b0;
         out_idx_ff  <= 3'd0;
         hash_ff     <= shabsh_pkg::H_INIT;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         bitlen_ff   <= bitlen_in;
         round_ff    <= round_in;
         fin_ff      <= fin_in;
         mark_ff     <= mark_in;
         last_blk_ff <= last_blk_in;
         out_idx_ff  <= out_idx_in;
         hash_ff     <= hash_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      blk_ff  <= blk_in;
   end

   // ports
   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_data.digest_word = hash_ff[out_idx_ff];
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.last        = (out_idx_ff == shabsh_pkg::LAST_WORD);

`ifndef SYNTH
   // never accepting and presenting at once
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and result sides both active");

   // round counter rests at zero between compressions
   a_round_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ROUND) |-> (round_ff == 6'd0))
      else $error("round counter not at zero outside compression");

   // final byte of a block starts a compression
   a_block_full : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.command == shabsh_pkg::CMD_ABSORB)
       && (cnt_ff == shabsh_pkg::LAST_BYTE)) |=> (state_ff == S_ROUND))
      else $error("full block did not start compression");

   // last digest transfer leaves a fresh message state
   a_fresh_msg : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last)
      |=> (req_ready && (cnt_ff == 6'd0) && (bitlen_ff == 64'd0)
           && (hash_ff == shabsh_pkg::H_INIT)))
      else $error("message state not cleared after digest");
`endif

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for the byte-serial sha-256 hasher
// holds its own sha-256 digest predictor and a scoreboard class for the digest words
// depends on shabsh_pkg and the sha256_byte_stream_hasher rtl
`timescale 1ns / 100ps

module tb_top;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 4;
   localparam int TARGET_ITEMS = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 150;
   localparam int IDLE_PCT     = 35;
   localparam int REPORT_MAX   = 10;

   // digest predictor and checker for the result channel
   class sha_digest_scoreboard;
      bit [31:0] round_tab[64];
      bit [31:0] chain[8];
      bit [7:0]  block_bytes[64];
      bit [5:0]  fill;
      bit [63:0] msg_bits;
      shabsh_pkg::rsp_type digest_q[$];
      int        errors;
      int        messages;
      int        bytes_taken;
      int        words_checked;

      function new();
         round_tab = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
         };
         errors        = 0;
         messages      = 0;
         bytes_taken   = 0;
         words_checked = 0;
         start_message();
      endfunction

      // fresh chaining value, empty buffer, zero length
      function void start_message();
         for (int i = 0; i < 8; i++) begin
            chain[i] = shabsh_pkg::H_INIT[i];
         end
         fill     = '0;
         msg_bits = '0;
      endfunction

      function bit [31:0] ror(bit [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // one 64-round compression of block_bytes into the chaining value
      function void compress_block();
         bit [31:0] w[64];
         bit [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
         for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
         end
         for (int i = 16; i < 64; i++) begin
            s0   = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1   = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                     chain[4], chain[5], chain[6], chain[7]};
         for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + round_tab[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h  = g;
            g  = f;
            f  = e;
            e  = d + t1;
            d  = c;
            c  = b;
            b  = a;
            a  = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      // accepted request transfer: absorb a byte or pad and queue the digest
      function void note_request(shabsh_pkg::req_type item);
         int                  pos;
         shabsh_pkg::rsp_type word;
         if (item.command == shabsh_pkg::CMD_ABSORB) begin
            block_bytes[fill] = item.data_byte;
            fill              = fill + 6'd1;
            msg_bits          = msg_bits + 64'd8;
            bytes_taken++;
            if (fill == '0) begin
               compress_block();
            end
         end else begin
            pos              = fill;
            block_bytes[pos] = shabsh_pkg::PAD_MARK;
            pos++;
            // no room for the length field: spill into a second block
            if (pos > int'(shabsh_pkg::PAD_LEN_POS)) begin
               while (pos < 64) begin
                  block_bytes[pos] = 8'h00;
                  pos++;
               end
               compress_block();
               pos = 0;
            end
            while (pos < int'(shabsh_pkg::PAD_LEN_POS)) begin
               block_bytes[pos] = 8'h00;
               pos++;
            end
            for (int k = 0; k < 8; k++) begin
               block_bytes[int'(shabsh_pkg::PAD_LEN_POS) + k] = msg_bits[63 - 8*k -: 8];
            end
            compress_block();
            for (int k = 0; k < 8; k++) begin
               word.digest_word = chain[k];
               word.word_index  = 3'(k);
               word.last        = (3'(k) == shabsh_pkg::LAST_WORD);
               digest_q.push_back(word);
            end
            messages++;
            start_message();
         end
      endfunction

      function void report(string what, bit [31:0] want, bit [31:0] got);
         errors++;
         if (errors <= REPORT_MAX) begin
            $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
         end
      endfunction

      // accepted result transfer: compare with the oldest queued digest word
      function void check_digest(shabsh_pkg::rsp_type got);
         shabsh_pkg::rsp_type want;
         if (digest_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX) begin
               $display("[%0t] digest word %h (index %0d) with nothing outstanding",
                        $time, got.digest_word, got.word_index);
            end
            return;
         end
         want = digest_q.pop_front();
         words_checked++;
         if (got.digest_word !== want.digest_word) begin
            report("digest_word", want.digest_word, got.digest_word);
         end
         if (got.word_index !== want.word_index) begin
            report("word_index", 32'(want.word_index), 32'(got.word_index));
         end
         if (got.last !== want.last) begin
            report("last", 32'(want.last), 32'(got.last));
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   shabsh_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   shabsh_pkg::rsp_type rsp_data;

   sha_digest_scoreboard digests;
   int   items_sent;
   int   longest_msg;
   int   stall_cycles;
   logic steady;

   sha256_byte_stream_hasher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // stretch of transfers in which neither side idles
   assign steady = (items_sent >= 130) && (items_sent < 210);

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            digests.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            digests.check_digest(rsp_data);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one request transfer, with a random gap after it
   task automatic send_request(input logic cmd, input logic [7:0] value);
      shabsh_pkg::req_type item;
      item.command   = cmd;
      item.data_byte = value;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      items_sent++;
      while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // random message of a given length, closed by a finish with a junk byte
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_request(shabsh_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
      end
      send_request(shabsh_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
      if (len > longest_msg) begin
         longest_msg = len;
      end
   endtask

   initial begin
      int pad_lengths[$] = '{55, 56, 63, 64};
      int len;
      digests      = new();
      items_sent   = 0;
      longest_msg  = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message, once with a quiet and once with a full ignored byte
      send_request(shabsh_pkg::CMD_FINISH, 8'h00);
      send_request(shabsh_pkg::CMD_FINISH, 8'hff);
      // the classic three-byte message
      send_request(shabsh_pkg::CMD_ABSORB, 8'h61);
      send_request(shabsh_pkg::CMD_ABSORB, 8'h62);
      send_request(shabsh_pkg::CMD_ABSORB, 8'h63);
      send_request(shabsh_pkg::CMD_FINISH, 8'h00);
      // byte extremes and alternating bit patterns
      send_request(shabsh_pkg::CMD_ABSORB, 8'h00);
      send_request(shabsh_pkg::CMD_ABSORB, 8'hff);
      send_request(shabsh_pkg::CMD_FINISH, 8'h5a);
      send_request(shabsh_pkg::CMD_ABSORB, 8'h55);
      send_request(shabsh_pkg::CMD_ABSORB, 8'haa);
      send_request(shabsh_pkg::CMD_ABSORB, 8'h80);
      send_request(shabsh_pkg::CMD_FINISH, 8'ha5);

      // random messages: mostly short, plus the padding boundary lengths
      while ((items_sent < TARGET_ITEMS) || (pad_lengths.size() != 0)) begin
         if ((pad_lengths.size() != 0) && ($urandom_range(0, 2) != 0)) begin
            len = pad_lengths.pop_front();
         end else begin
            len = $urandom_range(0, 20);
         end
         send_message(len);
      end
      req_valid <= 1'b0;
      // let the monitor take the final request transfer first
      @(posedge clock);

      // wait for the outstanding digests, then let the block settle
      while (digests.digest_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request transfers: %0d messages, %0d message bytes, longest %0d",
               items_sent, digests.messages, digests.bytes_taken, longest_msg);
      $display("checked %0d digest words, %0d mismatches", digests.words_checked,
               digests.errors);
      if (digests.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/shabsh_pkg.sv
rtl/shabsh_round.sv
rtl/sha256_byte_stream_hasher.sv
verif/tb_top.sv
